// ----- rtl/vpp_pkg.sv -----
package vpp_pkg;

    localparam int TRIG_BITS = 14;
    localparam int IN_W      = 32;
    localparam int CFG_W     = 16;
    localparam int SIZE_W    = 14;
    localparam int PIX_W     = 24;
    localparam int IDX_W     = 3;

    // Widths of the intermediate values of the rotation and projection.
    localparam int PROD_W  = 48;   // 32 x 16 product
    localparam int ROT1_W  = 49;   // sum of two first rotation products
    localparam int T_W     = 36;   // rounded first rotation value
    localparam int TPR_W   = 52;   // 36 x 16 product
    localparam int ROT2_W  = 53;   // sum of two second rotation products
    localparam int R_W     = 40;   // rounded rotated coordinate
    localparam int RX_W    = 36;   // rounded rotated x
    localparam int NUMS_W  = 57;   // signed coordinate times focal length
    localparam int NUM_W   = 56;   // magnitude of the numerator
    localparam int DEN_W   = 40;   // magnitude of the depth
    localparam int QS_W    = 58;   // signed rounded quotient
    localparam int SUM_W   = 59;   // quotient plus half the canvas size

    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        CFG_COS_YAW   = 3'd0,
        CFG_SIN_YAW   = 3'd1,
        CFG_COS_PITCH = 3'd2,
        CFG_SIN_PITCH = 3'd3,
        CFG_FOCAL     = 3'd4,
        CFG_WIDTH     = 3'd5,
        CFG_HEIGHT    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [IN_W-1:0] vert_x;
        logic signed [IN_W-1:0] vert_y;
        logic signed [IN_W-1:0] vert_z;
    } vertex_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    visible;
        logic signed [IN_W-1:0]  depth;
    } result_t;

    // Per-vertex flags and values carried alongside the divider.
    typedef struct packed {
        logic [DEN_W-1:0]       den;
        logic                   neg_x;
        logic                   neg_y;
        logic                   pos_x;
        logic                   pos_y;
        logic                   zero;
        logic                   visible;
        logic signed [IN_W-1:0] depth;
    } side_t;

    // Shift right by the trigonometric fraction, rounding half away from zero.
    function automatic logic signed [R_W-1:0] rshr(input logic signed [ROT2_W-1:0] v);
        logic [ROT2_W-1:0] mag;
        logic [ROT2_W:0]   sum;
        logic [R_W-1:0]    q;
        mag = v[ROT2_W-1] ? ROT2_W'(-v) : ROT2_W'(v);
        sum = {1'b0, mag} + (ROT2_W+1)'(1 << (TRIG_BITS - 1));
        q   = R_W'(sum >> TRIG_BITS);
        return v[ROT2_W-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ----- rtl/vertex_perspective_project.sv -----
// Vertex transform: yaw and pitch rotation followed by perspective projection.
//
// Input channel: a vertex word is taken at each rising edge where start is
// high and busy is low. busy is never raised, so one vertex may be issued in
// every cycle. Results leave on the result port, marked by done for exactly
// one cycle; the receiver cannot hold a result back and none is needed,
// since the pipeline never stalls.
// Configuration channel: cfg_valid with cfg_index and cfg_data writes one
// trigonometry, focal length or canvas register; cfg_ready is always high
// and an unknown index is ignored. Write registers only while no vertex is
// in flight.
// From accept to done a vertex passes the stages of multiply, add and
// rounding, a restoring divider retiring one quotient bit per stage (two
// lanes, x and y, sharing the depth as divisor), then rounding, centring and
// saturation. Throughput is one vertex per cycle.
// Reset clears all valid bits, so nothing in flight is delivered, and loads
// the registers with an identity rotation, focal length 512 and a 1024 by
// 768 canvas.
module vertex_perspective_project (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  vpp_pkg::vertex_t             vertex,
    output logic                         done,
    output vpp_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [vpp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [vpp_pkg::CFG_W-1:0]    cfg_data
);

    localparam int DIV_STEPS = vpp_pkg::NUM_W;
    localparam int LATENCY   = 8 + DIV_STEPS + 2;

    // Configuration registers.
    logic signed [vpp_pkg::CFG_W-1:0]  cos_yaw_reg, sin_yaw_reg;
    logic signed [vpp_pkg::CFG_W-1:0]  cos_pitch_reg, sin_pitch_reg;
    logic        [vpp_pkg::CFG_W-1:0]  focal_reg;
    logic        [vpp_pkg::SIZE_W-1:0] width_reg, height_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_yaw_reg   <= 16'sd16384;
            sin_yaw_reg   <= 16'sd0;
            cos_pitch_reg <= 16'sd16384;
            sin_pitch_reg <= 16'sd0;
            focal_reg     <= 16'd512;
            width_reg     <= 14'd1024;
            height_reg    <= 14'd768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vpp_pkg::cfg_index_t'(cfg_index))
                vpp_pkg::CFG_COS_YAW:   cos_yaw_reg   <= $signed(cfg_data);
                vpp_pkg::CFG_SIN_YAW:   sin_yaw_reg   <= $signed(cfg_data);
                vpp_pkg::CFG_COS_PITCH: cos_pitch_reg <= $signed(cfg_data);
                vpp_pkg::CFG_SIN_PITCH: sin_pitch_reg <= $signed(cfg_data);
                vpp_pkg::CFG_FOCAL:     focal_reg     <= cfg_data;
                vpp_pkg::CFG_WIDTH:     width_reg     <= cfg_data[vpp_pkg::SIZE_W-1:0];
                vpp_pkg::CFG_HEIGHT:    height_reg    <= cfg_data[vpp_pkg::SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Valid bits of the arithmetic stages.
    logic [6:0] vld_reg;
    logic       accept;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[5:0], accept};
    end

    // Stage 1: the four yaw products.
    logic signed [vpp_pkg::PROD_W-1:0] xcy_reg, ysy_reg, xsy_reg, ycy_reg;
    logic signed [vpp_pkg::IN_W-1:0]   z1_reg;

    always_ff @(posedge clk)
    begin
        xcy_reg <= vertex.vert_x * cos_yaw_reg;
        ysy_reg <= vertex.vert_y * sin_yaw_reg;
        xsy_reg <= vertex.vert_x * sin_yaw_reg;
        ycy_reg <= vertex.vert_y * cos_yaw_reg;
        z1_reg  <= vertex.vert_z;
    end

    // Stage 2: yaw sums.
    logic signed [vpp_pkg::ROT1_W-1:0] u2_reg, tsum2_reg;
    logic signed [vpp_pkg::IN_W-1:0]   z2_reg;

    always_ff @(posedge clk)
    begin
        u2_reg    <= vpp_pkg::ROT1_W'(xcy_reg) - vpp_pkg::ROT1_W'(ysy_reg);
        tsum2_reg <= vpp_pkg::ROT1_W'(xsy_reg) + vpp_pkg::ROT1_W'(ycy_reg);
        z2_reg    <= z1_reg;
    end

    // Stage 3: round t back to the input format; depth products with z.
    logic signed [vpp_pkg::T_W-1:0]    t3_reg;
    logic signed [vpp_pkg::ROT1_W-1:0] u3_reg;
    logic signed [vpp_pkg::PROD_W-1:0] zsp3_reg, zcp3_reg;

    always_ff @(posedge clk)
    begin
        t3_reg   <= vpp_pkg::T_W'(vpp_pkg::rshr(vpp_pkg::ROT2_W'(tsum2_reg)));
        u3_reg   <= u2_reg;
        zsp3_reg <= z2_reg * sin_pitch_reg;
        zcp3_reg <= z2_reg * cos_pitch_reg;
    end

    // Stage 4: pitch products with t.
    logic signed [vpp_pkg::TPR_W-1:0]  tcp4_reg, tsp4_reg;
    logic signed [vpp_pkg::PROD_W-1:0] zsp4_reg, zcp4_reg;
    logic signed [vpp_pkg::ROT1_W-1:0] u4_reg;

    always_ff @(posedge clk)
    begin
        tcp4_reg <= t3_reg * cos_pitch_reg;
        tsp4_reg <= t3_reg * sin_pitch_reg;
        zsp4_reg <= zsp3_reg;
        zcp4_reg <= zcp3_reg;
        u4_reg   <= u3_reg;
    end

    // Stage 5: pitch sums, rounding of x.
    logic signed [vpp_pkg::ROT2_W-1:0] v5_reg, w5_reg;
    logic signed [vpp_pkg::RX_W-1:0]   rx5_reg;

    always_ff @(posedge clk)
    begin
        v5_reg  <= vpp_pkg::ROT2_W'(tcp4_reg) - vpp_pkg::ROT2_W'(zsp4_reg);
        w5_reg  <= vpp_pkg::ROT2_W'(tsp4_reg) + vpp_pkg::ROT2_W'(zcp4_reg);
        rx5_reg <= vpp_pkg::RX_W'(vpp_pkg::rshr(vpp_pkg::ROT2_W'(u4_reg)));
    end

    // Stage 6: rounding of y and depth.
    logic signed [vpp_pkg::RX_W-1:0] rx6_reg;
    logic signed [vpp_pkg::R_W-1:0]  ry6_reg, rz6_reg;

    always_ff @(posedge clk)
    begin
        rx6_reg <= rx5_reg;
        ry6_reg <= vpp_pkg::rshr(v5_reg);
        rz6_reg <= vpp_pkg::rshr(w5_reg);
    end

    // Stage 7: scale by the focal length.
    logic signed [vpp_pkg::NUMS_W-1:0] numx7_reg, numy7_reg;
    logic signed [vpp_pkg::R_W-1:0]    rz7_reg;
    logic signed [vpp_pkg::CFG_W:0]    foc_s;

    assign foc_s = $signed({1'b0, focal_reg});

    always_ff @(posedge clk)
    begin
        numx7_reg <= rx6_reg * foc_s;
        numy7_reg <= ry6_reg * foc_s;
        rz7_reg   <= rz6_reg;
    end

    // Stage 8 feeds the divider: magnitudes, signs and the depth output.
    localparam logic signed [vpp_pkg::R_W-1:0] DEPTH_MAX = vpp_pkg::R_W'(64'sd2147483647);
    localparam logic signed [vpp_pkg::R_W-1:0] DEPTH_MIN = vpp_pkg::R_W'(-64'sd2147483648);

    logic [vpp_pkg::DEN_W-1:0] remx_reg [DIV_STEPS+1];
    logic [vpp_pkg::DEN_W-1:0] remy_reg [DIV_STEPS+1];
    logic [vpp_pkg::NUM_W-1:0] numx_reg [DIV_STEPS+1];
    logic [vpp_pkg::NUM_W-1:0] numy_reg [DIV_STEPS+1];
    vpp_pkg::side_t            side_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0]        dvld_reg;

    vpp_pkg::side_t side_next;
    logic           rz_pos;

    always_comb
    begin
        rz_pos            = (rz7_reg > 0);
        side_next.den     = rz7_reg[vpp_pkg::R_W-1] ? vpp_pkg::DEN_W'(-rz7_reg)
                                                    : vpp_pkg::DEN_W'(rz7_reg);
        // The divisor is the negated depth, so it is negative when depth is positive.
        side_next.neg_x   = numx7_reg[vpp_pkg::NUMS_W-1] != rz_pos;
        side_next.neg_y   = numy7_reg[vpp_pkg::NUMS_W-1] != rz_pos;
        side_next.pos_x   = numx7_reg > 0;
        side_next.pos_y   = numy7_reg > 0;
        side_next.zero    = rz7_reg == 0;
        side_next.visible = rz_pos;
        if (rz7_reg > DEPTH_MAX)
            side_next.depth = vpp_pkg::IN_W'(DEPTH_MAX);
        else if (rz7_reg < DEPTH_MIN)
            side_next.depth = vpp_pkg::IN_W'(DEPTH_MIN);
        else
            side_next.depth = vpp_pkg::IN_W'(rz7_reg);
    end

    always_ff @(posedge clk)
    begin
        remx_reg[0] <= '0;
        remy_reg[0] <= '0;
        numx_reg[0] <= numx7_reg[vpp_pkg::NUMS_W-1] ? vpp_pkg::NUM_W'(-numx7_reg)
                                                    : vpp_pkg::NUM_W'(numx7_reg);
        numy_reg[0] <= numy7_reg[vpp_pkg::NUMS_W-1] ? vpp_pkg::NUM_W'(-numy7_reg)
                                                    : vpp_pkg::NUM_W'(numy7_reg);
        side_reg[0] <= side_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvld_reg[0] <= 1'b0;
        else
            dvld_reg[0] <= vld_reg[6];
    end

    // Restoring divider: each stage shifts in one numerator bit and retires one
    // quotient bit into the bottom of the numerator word.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [vpp_pkg::DEN_W:0]   shx, shy;
        logic                      gx, gy;
        logic [vpp_pkg::DEN_W-1:0] remx_next, remy_next;

        always_comb
        begin
            shx       = {remx_reg[k], numx_reg[k][vpp_pkg::NUM_W-1]};
            shy       = {remy_reg[k], numy_reg[k][vpp_pkg::NUM_W-1]};
            gx        = shx >= {1'b0, side_reg[k].den};
            gy        = shy >= {1'b0, side_reg[k].den};
            remx_next = gx ? vpp_pkg::DEN_W'(shx - {1'b0, side_reg[k].den})
                           : shx[vpp_pkg::DEN_W-1:0];
            remy_next = gy ? vpp_pkg::DEN_W'(shy - {1'b0, side_reg[k].den})
                           : shy[vpp_pkg::DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            remx_reg[k+1] <= remx_next;
            remy_reg[k+1] <= remy_next;
            numx_reg[k+1] <= {numx_reg[k][vpp_pkg::NUM_W-2:0], gx};
            numy_reg[k+1] <= {numy_reg[k][vpp_pkg::NUM_W-2:0], gy};
            side_reg[k+1] <= side_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvld_reg[k+1] <= 1'b0;
            else
                dvld_reg[k+1] <= dvld_reg[k];
        end
    end

    // Round half away from zero and apply the sign in one add:
    // -(q + r) equals ~q + (1 - r).
    logic signed [vpp_pkg::QS_W-1:0] qsx_reg, qsy_reg;
    vpp_pkg::side_t                  rside_reg;
    logic                            rvld_reg;
    logic                            rndx, rndy;
    logic [vpp_pkg::NUM_W-1:0]       qmx, qmy;

    always_comb
    begin
        qmx  = numx_reg[DIV_STEPS];
        qmy  = numy_reg[DIV_STEPS];
        rndx = {remx_reg[DIV_STEPS], 1'b0} >= {1'b0, side_reg[DIV_STEPS].den};
        rndy = {remy_reg[DIV_STEPS], 1'b0} >= {1'b0, side_reg[DIV_STEPS].den};
    end

    always_ff @(posedge clk)
    begin
        qsx_reg   <= side_reg[DIV_STEPS].neg_x
                   ? $signed({2'b11, ~qmx} + vpp_pkg::QS_W'(!rndx))
                   : $signed({2'b00, qmx} + vpp_pkg::QS_W'(rndx));
        qsy_reg   <= side_reg[DIV_STEPS].neg_y
                   ? $signed({2'b11, ~qmy} + vpp_pkg::QS_W'(!rndy))
                   : $signed({2'b00, qmy} + vpp_pkg::QS_W'(rndy));
        rside_reg <= side_reg[DIV_STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvld_reg <= 1'b0;
        else
            rvld_reg <= dvld_reg[DIV_STEPS];
    end

    // Centre on the canvas and saturate; zero depth pins each pixel to a rail.
    localparam logic signed [vpp_pkg::SUM_W-1:0] SUM_MAX = vpp_pkg::SUM_W'(vpp_pkg::PIX_MAX);
    localparam logic signed [vpp_pkg::SUM_W-1:0] SUM_MIN = vpp_pkg::SUM_W'(vpp_pkg::PIX_MIN);

    logic signed [vpp_pkg::SUM_W-1:0] sumx, sumy;
    vpp_pkg::result_t                 result_next;
    vpp_pkg::result_t                 result_reg;
    logic                             done_reg;

    always_comb
    begin
        sumx = vpp_pkg::SUM_W'(qsx_reg)
             + $signed({{(vpp_pkg::SUM_W-vpp_pkg::SIZE_W+1){1'b0}}, width_reg[vpp_pkg::SIZE_W-1:1]});
        sumy = vpp_pkg::SUM_W'(qsy_reg)
             + $signed({{(vpp_pkg::SUM_W-vpp_pkg::SIZE_W+1){1'b0}}, height_reg[vpp_pkg::SIZE_W-1:1]});

        if (rside_reg.zero)
            result_next.pixel_x = rside_reg.pos_x ? vpp_pkg::PIX_MIN : vpp_pkg::PIX_MAX;
        else if (sumx > SUM_MAX)
            result_next.pixel_x = vpp_pkg::PIX_MAX;
        else if (sumx < SUM_MIN)
            result_next.pixel_x = vpp_pkg::PIX_MIN;
        else
            result_next.pixel_x = vpp_pkg::PIX_W'(sumx);

        if (rside_reg.zero)
            result_next.pixel_y = rside_reg.pos_y ? vpp_pkg::PIX_MIN : vpp_pkg::PIX_MAX;
        else if (sumy > SUM_MAX)
            result_next.pixel_y = vpp_pkg::PIX_MAX;
        else if (sumy < SUM_MIN)
            result_next.pixel_y = vpp_pkg::PIX_MIN;
        else
            result_next.pixel_y = vpp_pkg::PIX_W'(sumy);

        result_next.visible = rside_reg.visible;
        result_next.depth   = rside_reg.depth;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rvld_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // Every result traces back to a vertex accepted a fixed time earlier.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching accepted vertex");

    // A visible vertex has strictly positive depth.
    a_visible_depth: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.visible |-> !result.depth[vpp_pkg::IN_W-1] && result.depth != 0)
        else $error("visible flag disagrees with depth");

    // Zero depth drives both pixels to a rail.
    a_zero_rail: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.depth == 0 |->
            (result.pixel_x == vpp_pkg::PIX_MIN || result.pixel_x == vpp_pkg::PIX_MAX) &&
            (result.pixel_y == vpp_pkg::PIX_MIN || result.pixel_y == vpp_pkg::PIX_MAX))
        else $error("zero depth pixel not saturated");
`endif

endmodule

// ----- test/vertex_perspective_project_test.sv -----
`timescale 1ns / 100ps

module vertex_perspective_project_test;

    // Clock, reset and the ports of the block.
    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    vpp_pkg::vertex_t            vertex;
    logic                        done;
    vpp_pkg::result_t            result;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [vpp_pkg::IDX_W-1:0]   cfg_index;
    logic [vpp_pkg::CFG_W-1:0]   cfg_data;

    vertex_perspective_project DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vertex    (vertex),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The drain waits longer than the pipeline depth of the block.
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    // The testbench's own copy of the seven registers.
    logic signed [15:0] cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
    logic [15:0]        focal_q;
    logic [13:0]        width_q, height_q;

    // Vertex words waiting to be issued, each with the idle gap before it, and the
    // projected results that the block still owes.
    vpp_pkg::vertex_t vertex_queue[$];
    int               gap_queue[$];
    vpp_pkg::result_t projected_queue[$];

    int  error_count;
    int  result_count;
    int  issued_count;
    int  cycle_count;
    int  gap_left;

    // Cfg write handshake: the initial block raises a request and waits for the
    // channel to take it, so that all driving stays on the clock edge.
    bit                  cfg_req;
    bit                  cfg_ack;
    vpp_pkg::cfg_index_t cfg_req_index;
    logic [15:0]         cfg_req_data;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rounding shift by the trigonometric fraction, half away from zero.
    function automatic longint round_trig(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (vpp_pkg::TRIG_BITS - 1))) >>> vpp_pkg::TRIG_BITS;
        return (v < 0) ? -m : m;
    endfunction

    // One screen coordinate: coordinate times focal length over the negated
    // depth, rounded half away from zero, centred and saturated.
    function automatic logic signed [vpp_pkg::PIX_W-1:0] screen_coord(input longint r,
                                                                      input longint rz,
                                                                      input logic [13:0] size);
        longint num, den, q;
        longint unsigned nm, dm, qm, rm;
        bit neg;
        num = r * longint'(focal_q);
        den = -rz;
        // A zero depth counts as a negative zero in the divisor, so the sign of
        // the numerator alone picks the rail.
        if (rz == 0)
            return (num > 0) ? vpp_pkg::PIX_MIN : vpp_pkg::PIX_MAX;
        nm  = (num < 0) ? longint'(-num) : longint'(num);
        dm  = (den < 0) ? longint'(-den) : longint'(den);
        neg = (num < 0) != (den < 0);
        qm  = nm / dm;
        rm  = nm % dm;
        if (2 * rm >= dm)
            qm++;
        q = neg ? -longint'(qm) : longint'(qm);
        q += longint'(size >> 1);
        if (q > longint'(vpp_pkg::PIX_MAX))
            q = longint'(vpp_pkg::PIX_MAX);
        if (q < longint'(vpp_pkg::PIX_MIN))
            q = longint'(vpp_pkg::PIX_MIN);
        return vpp_pkg::PIX_W'(q);
    endfunction

    // Rotation by yaw then pitch and the projection of one vertex.
    function automatic vpp_pkg::result_t project_vertex(input vpp_pkg::vertex_t v);
        vpp_pkg::result_t res;
        longint x, y, z, u, t, pv, w, rx, ry, rz, d;
        x  = longint'(v.vert_x);
        y  = longint'(v.vert_y);
        z  = longint'(v.vert_z);
        u  = x * longint'(cos_yaw_q) - y * longint'(sin_yaw_q);
        t  = round_trig(x * longint'(sin_yaw_q) + y * longint'(cos_yaw_q));
        pv = t * longint'(cos_pitch_q) - z * longint'(sin_pitch_q);
        w  = t * longint'(sin_pitch_q) + z * longint'(cos_pitch_q);
        rx = round_trig(u);
        ry = round_trig(pv);
        rz = round_trig(w);
        d  = rz;
        if (d > 64'sd2147483647)
            d = 64'sd2147483647;
        if (d < -64'sd2147483648)
            d = -64'sd2147483648;
        res.pixel_x = screen_coord(rx, rz, width_q);
        res.pixel_y = screen_coord(ry, rz, height_q);
        res.visible = (rz > 0);
        res.depth   = vpp_pkg::IN_W'(d);
        return res;
    endfunction

    // Mirrors a register write into the local copy.
    task automatic note_register(input vpp_pkg::cfg_index_t idx, input logic [15:0] data);
        case (idx)
            vpp_pkg::CFG_COS_YAW:   cos_yaw_q   = data;
            vpp_pkg::CFG_SIN_YAW:   sin_yaw_q   = data;
            vpp_pkg::CFG_COS_PITCH: cos_pitch_q = data;
            vpp_pkg::CFG_SIN_PITCH: sin_pitch_q = data;
            vpp_pkg::CFG_FOCAL:     focal_q     = data;
            vpp_pkg::CFG_WIDTH:     width_q     = data[13:0];
            vpp_pkg::CFG_HEIGHT:    height_q    = data[13:0];
            default:       ;
        endcase
    endtask

    // Driver: issues queued vertex words after their drawn gaps and carries
    // register writes on the configuration channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            vertex    <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            cfg_ack   <= 1'b0;
            gap_left  <= 0;
        end
        else
        begin
            // A word counts as issued at the edge where start is high and busy low.
            if (start && !busy)
            begin
                projected_queue.push_back(project_vertex(vertex));
                issued_count <= issued_count + 1;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (vertex_queue.size() > 0)
                begin
                    if (gap_queue[0] > 0)
                    begin
                        start    <= 1'b0;
                        gap_left <= gap_queue[0] - 1;
                        gap_queue[0] = 0;
                    end
                    else
                    begin
                        start  <= 1'b1;
                        vertex <= vertex_queue.pop_front();
                        void'(gap_queue.pop_front());
                    end
                end
                else
                    start <= 1'b0;
            end

            // Register write: held until cfg_ready takes it.
            if (cfg_valid && cfg_ready)
            begin
                note_register(vpp_pkg::cfg_index_t'(cfg_index), cfg_data);
                cfg_valid <= 1'b0;
                cfg_ack   <= 1'b1;
            end
            else if (cfg_req && !cfg_valid && !cfg_ack)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_req_index;
                cfg_data  <= cfg_req_data;
            end
            else if (!cfg_req)
                cfg_ack <= 1'b0;
        end
    end

    // Monitor: every done word is checked against the oldest projection.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (done)
            begin
                result_count <= result_count + 1;
                if (projected_queue.size() == 0)
                begin
                    $error("result word with no projection waiting");
                    error_count++;
                end
                else
                begin
                    vpp_pkg::result_t exp_r;
                    exp_r = projected_queue.pop_front();
                    if (result.pixel_x !== exp_r.pixel_x)
                    begin
                        $error("pixel_x expected %0d actual %0d", exp_r.pixel_x, result.pixel_x);
                        error_count++;
                    end
                    if (result.pixel_y !== exp_r.pixel_y)
                    begin
                        $error("pixel_y expected %0d actual %0d", exp_r.pixel_y, result.pixel_y);
                        error_count++;
                    end
                    if (result.visible !== exp_r.visible)
                    begin
                        $error("visible expected %0d actual %0d", exp_r.visible, result.visible);
                        error_count++;
                    end
                    if (result.depth !== exp_r.depth)
                    begin
                        $error("depth expected %0d actual %0d", exp_r.depth, result.depth);
                        error_count++;
                    end
                end
            end
        end
    end

    // Global time limit: well beyond the slowest correct run.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("vertex_perspective_project_test: errors");
            $finish;
        end
    end

    task automatic write_register(input vpp_pkg::cfg_index_t idx, input logic [15:0] data);
        cfg_req_index = idx;
        cfg_req_data  = data;
        cfg_req       = 1'b1;
        @(posedge clk);
        while (!cfg_ack)
            @(posedge clk);
        cfg_req = 1'b0;
        while (cfg_ack)
            @(posedge clk);
    endtask

    // Waits until every issued word has come back, then drains for longer than the pipeline depth.
    task automatic wait_idle();
        @(posedge clk);
        while (vertex_queue.size() > 0 || start || projected_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
            2: return 32'(int'($urandom_range(0, 200)) - 100);
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'(int'($urandom_range(0, 20)) - 10) <<< 16;
        endcase
    endfunction

    task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input bit gapped);
        vpp_pkg::vertex_t v;
        v.vert_x = x;
        v.vert_y = y;
        v.vert_z = z;
        vertex_queue.push_back(v);
        gap_queue.push_back(gapped ? $urandom_range(0, 7) : 0);
    endtask

    // A random trigonometric register, mostly inside the unit range, sometimes
    // any bit pattern at all.
    function automatic logic [15:0] rand_trig();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial
    begin
        int   phase;
        logic [15:0] foc;
        rst_n       = 1'b0;
        cfg_req     = 1'b0;
        error_count = 0;
        result_count = 0;
        issued_count = 0;
        cycle_count = 0;
        cos_yaw_q   = 16'sd16384;
        sin_yaw_q   = 16'sd0;
        cos_pitch_q = 16'sd16384;
        sin_pitch_q = 16'sd0;
        focal_q     = 16'd512;
        width_q     = 14'd1024;
        height_q    = 14'd768;
        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        // Directed words at the reset registers: field extremes, zero depth with
        // numerators of each sign, and depths on both sides of zero.
        queue_vertex(32'h0, 32'h0, 32'h0, 0);
        queue_vertex(32'h00010000, 32'hFFFF0000, 32'h0, 0);
        queue_vertex(32'hFFFF0000, 32'h00010000, 32'h0, 1);
        queue_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        queue_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0);
        queue_vertex(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1);
        queue_vertex(32'h00050000, 32'h00030000, 32'hFFF60000, 0);
        queue_vertex(32'h00050000, 32'h00030000, 32'h000A0000, 0);
        queue_vertex(32'h00000001, 32'hFFFFFFFF, 32'h00000001, 0);
        queue_vertex(32'h00030000, 32'h00000000, 32'hFFFA0000, 1);
        wait_idle();

        // Register extremes: rotations beyond unity, zero and largest focal
        // length, and the widest canvas.
        write_register(vpp_pkg::CFG_COS_YAW, 16'h8000);
        write_register(vpp_pkg::CFG_SIN_YAW, 16'h7FFF);
        write_register(vpp_pkg::CFG_COS_PITCH, -16'sd16384);
        write_register(vpp_pkg::CFG_SIN_PITCH, 16'sd16384);
        write_register(vpp_pkg::CFG_FOCAL, 16'hFFFF);
        write_register(vpp_pkg::CFG_WIDTH, 16'hFFFF);
        write_register(vpp_pkg::CFG_HEIGHT, 16'd8192);
        queue_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
        queue_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
        queue_vertex(32'h00010000, 32'h00020000, 32'h00030000, 0);
        queue_vertex(32'h0, 32'h0, 32'h0, 1);
        wait_idle();
        write_register(vpp_pkg::CFG_FOCAL, 16'h0000);
        write_register(vpp_pkg::CFG_WIDTH, 16'h0000);
        write_register(vpp_pkg::CFG_HEIGHT, 16'h3FFF);
        queue_vertex(32'h00010000, 32'h00020000, 32'hFFFD0000, 0);
        queue_vertex(32'h12345678, 32'h9ABCDEF0, 32'h0, 0);
        wait_idle();

        // Random phases, each with its own register setting. Some phases
        // stream back to back with no gaps at all.
        for (phase = 0; phase < 13; phase++)
        begin
            bit gapped;
            write_register(vpp_pkg::CFG_COS_YAW, rand_trig());
            write_register(vpp_pkg::CFG_SIN_YAW, rand_trig());
            write_register(vpp_pkg::CFG_COS_PITCH, rand_trig());
            write_register(vpp_pkg::CFG_SIN_PITCH, rand_trig());
            foc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
            write_register(vpp_pkg::CFG_FOCAL, foc);
            write_register(vpp_pkg::CFG_WIDTH, 16'($urandom));
            write_register(vpp_pkg::CFG_HEIGHT, 16'($urandom));
            gapped = (phase % 3) != 0;
            repeat (150)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_vertex(rand_coord(), rand_coord(), 32'h0, gapped);
                else
                    queue_vertex(rand_coord(), rand_coord(), rand_coord(), gapped);
            end
            wait_idle();
        end

        $display("Issued %0d vertex words over 16 register settings; %0d results checked.",
                 issued_count, result_count);
        if (error_count == 0)
            $display("vertex_perspective_project_test: clean");
        else
            $display("vertex_perspective_project_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/vpp_pkg.sv
rtl/vertex_perspective_project.sv
test/vertex_perspective_project_test.sv
